### hdl/rsx_pkg.sv
`default_nettype none

package rsx_pkg;

    // command codes carried by a start item
    localparam logic [7:0] CMD_WRITE = 8'h01;
    localparam logic [7:0] CMD_READ  = 8'h02;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // completion status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ADDR_BAD = 3'd1;
    localparam logic [2:0] ST_NOT_RDY  = 3'd2;
    localparam logic [2:0] ST_BAD_ACK  = 3'd3;
    localparam logic [2:0] ST_SUM_BAD  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_PAYLOAD_LOW  = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_HIGH = 2'd1;
    localparam logic [1:0] REG_ACK_VALUE    = 2'd2;

    localparam int PAYLOAD_LEN = 10;
    localparam int MAX_READ    = 3;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        JOB_SINGLE,
        JOB_WRITE,
        JOB_READ
    } t_job_type;

    // work handed from the front to the back
    typedef struct packed {
        t_job_type              jtype;
        logic [1:0]             kind;
        logic [7:0]             value;
        logic                   ninth;
        logic                   de;
        logic [2:0]             status;
        logic [MAX_READ-1:0][7:0] data;
    } t_job;

endpackage

`default_nettype wire

### hdl/rsx_queue.sv
`default_nettype none

module rsx_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  rsx_pkg::t_job   i_job,
    input  wire             i_pop,
    output rsx_pkg::t_job   o_head,
    output logic            o_empty,
    output logic            o_full
);
    import rsx_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QDEPTH));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/rsx_front.sv
`default_nettype none

module rsx_front #(
    parameter int READ_LEN = 3
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_full,
    input  wire             i_action,
    input  wire [7:0]       i_slave_address,
    input  wire [7:0]       i_command,
    input  wire [7:0]       i_rx_byte,
    input  wire [7:0]       i_ack_value,
    output logic            o_push,
    output rsx_pkg::t_job   o_job
);
    import rsx_pkg::*;

    localparam logic [1:0] LEN = 2'(READ_LEN);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR_ECHO,
        PH_CMD_ECHO,
        PH_ACK,
        PH_DATA,
        PH_SUM
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [7:0]              r_addr, n_addr;
    logic [7:0]              r_cmd, n_cmd;
    logic [7:0]              r_sum, n_sum;
    logic [1:0]              r_cnt, n_cnt;
    logic [MAX_READ-1:0][7:0] r_rx_data, n_rx_data;
    logic                    accept;
    logic [1:0]              cnt_inc;

    assign accept  = i_in_valid && !i_full;
    assign cnt_inc = r_cnt + 2'd1;

    // classify the item and build the job for the back end
    always_comb begin
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_cmd     = r_cmd;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_rx_data = r_rx_data;
        o_push        = 1'b0;
        o_job.jtype   = JOB_SINGLE;
        o_job.kind    = KIND_DONE;
        o_job.value   = 8'd0;
        o_job.ninth   = 1'b0;
        o_job.de      = 1'b0;
        o_job.status  = ST_OK;
        o_job.data    = r_rx_data;
        if (accept) begin
            if (!i_action) begin
                // start restarts even when busy
                n_addr      = i_slave_address;
                n_cmd       = i_command;
                n_sum       = 8'd0;
                n_cnt       = 2'd0;
                n_phase     = PH_ADDR_ECHO;
                o_push      = 1'b1;
                o_job.kind  = KIND_TX;
                o_job.value = i_slave_address;
                o_job.ninth = 1'b1;
                o_job.de    = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_ADDR_ECHO: begin
                        o_push = 1'b1;
                        if (i_rx_byte != r_addr) begin
                            n_phase      = PH_IDLE;
                            o_job.status = ST_ADDR_BAD;
                        end else if (r_cmd == CMD_WRITE || r_cmd == CMD_READ) begin
                            n_phase     = PH_CMD_ECHO;
                            o_job.kind  = KIND_TX;
                            o_job.value = r_cmd;
                            o_job.de    = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_CMD_ECHO: begin
                        if (i_rx_byte != r_cmd) begin
                            n_phase      = PH_IDLE;
                            o_push       = 1'b1;
                            o_job.status = ST_NOT_RDY;
                        end else if (r_cmd == CMD_WRITE) begin
                            n_phase     = PH_ACK;
                            o_push      = 1'b1;
                            o_job.jtype = JOB_WRITE;
                        end else begin
                            n_sum   = 8'd0;
                            n_cnt   = 2'd0;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_ACK: begin
                        n_phase      = PH_IDLE;
                        o_push       = 1'b1;
                        o_job.status = (i_rx_byte == i_ack_value) ? ST_OK : ST_BAD_ACK;
                    end
                    PH_DATA: begin
                        n_rx_data[r_cnt] = i_rx_byte;
                        n_sum            = r_sum + i_rx_byte;
                        n_cnt            = cnt_inc;
                        if (cnt_inc >= LEN) begin
                            n_phase = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        n_phase = PH_IDLE;
                        o_push  = 1'b1;
                        if (i_rx_byte != r_sum) begin
                            o_job.status = ST_SUM_BAD;
                        end else begin
                            o_job.jtype = JOB_READ;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // transaction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= 8'd0;
            r_cmd   <= 8'd0;
            r_sum   <= 8'd0;
            r_cnt   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_cmd   <= n_cmd;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
        end
    end

    // received data bytes
    always_ff @(posedge i_clk) begin
        r_rx_data <= n_rx_data;
    end

endmodule

`default_nettype wire

### hdl/rsx_back.sv
`default_nettype none

module rsx_back #(
    parameter int READ_LEN = 3
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  rsx_pkg::t_job                   i_head,
    input  wire                             i_empty,
    output logic                            o_pop,
    input  wire [rsx_pkg::PAYLOAD_LEN-1:0][7:0] i_payload,
    input  wire                             i_out_stall,
    output logic                            o_out_valid,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_byte_value,
    output logic                            o_ninth_bit,
    output logic                            o_driver_enable,
    output logic [2:0]                      o_status,
    output logic                            o_last
);
    import rsx_pkg::*;

    localparam logic [3:0] PLEN = 4'(PAYLOAD_LEN);
    localparam logic [3:0] RLEN = 4'(READ_LEN);

    logic       r_busy;
    t_job       r_job;
    logic [3:0] r_cnt;
    logic [7:0] r_sum;

    t_job       cur_job;
    logic [3:0] idx;
    logic [7:0] sum_in;
    logic [7:0] n_sum;
    logic       out_free;
    logic       emit;
    logic [1:0] res_kind;
    logic [7:0] res_value;
    logic       res_ninth;
    logic       res_de;
    logic [2:0] res_status;
    logic       res_last;

    assign cur_job  = r_busy ? r_job : i_head;
    assign idx      = r_busy ? r_cnt : 4'd0;
    assign sum_in   = r_busy ? r_sum : 8'd0;
    assign out_free = !o_out_valid || !i_out_stall;
    assign emit     = out_free && (r_busy || !i_empty);
    assign o_pop    = emit && !r_busy;

    // expand the current job into one result per cycle while the output is not stalled
    always_comb begin
        res_kind   = cur_job.kind;
        res_value  = cur_job.value;
        res_ninth  = cur_job.ninth;
        res_de     = cur_job.de;
        res_status = cur_job.status;
        res_last   = 1'b1;
        n_sum      = sum_in;
        case (cur_job.jtype)
            JOB_WRITE: begin
                res_kind   = KIND_TX;
                res_ninth  = 1'b0;
                res_de     = 1'b1;
                res_status = ST_OK;
                if (idx < PLEN) begin
                    res_value = i_payload[idx];
                    res_last  = 1'b0;
                    n_sum     = sum_in + i_payload[idx];
                end else begin
                    res_value = sum_in;
                end
            end
            JOB_READ: begin
                res_ninth  = 1'b0;
                res_de     = 1'b0;
                res_status = ST_OK;
                if (idx < RLEN) begin
                    res_kind  = KIND_DATA;
                    res_value = cur_job.data[idx[1:0]];
                    res_last  = 1'b0;
                end else begin
                    res_kind  = KIND_DONE;
                    res_value = 8'd0;
                end
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    // job progress and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                o_out_valid <= 1'b1;
                r_busy      <= !res_last;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // job copy, counters and output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_job           <= cur_job;
            r_cnt           <= idx + 4'd1;
            r_sum           <= n_sum;
            o_kind          <= res_kind;
            o_byte_value    <= res_value;
            o_ninth_bit     <= res_ninth;
            o_driver_enable <= res_de;
            o_status        <= res_status;
            o_last          <= res_last;
        end
    end

endmodule

`default_nettype wire

### hdl/rs485_master_exchange.sv
// Path: an item's job is queued, then the idle back end registers its first result.
// Throughput: one input item per cycle while the two-entry job queue has room; results
// leave at one per cycle unless the output stalls; a write's command echo yields eleven
// transmit bytes. Reset: synchronous, active low; clears phase, counters, queue and
// output valid, and loads the registers with their defaults. No clearing pass.
`default_nettype none

module rs485_master_exchange #(
    parameter int READ_LEN = 3
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_action,
    input  wire [7:0]   i_slave_address,
    input  wire [7:0]   i_command,
    input  wire [7:0]   i_rx_byte,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic        o_ninth_bit,
    output logic        o_driver_enable,
    output logic [2:0]  o_status,
    output logic        o_last,
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [63:0]  pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import rsx_pkg::*;

    logic [63:0] r_payload_low;
    logic [15:0] r_payload_high;
    logic [7:0]  r_ack_value;
    logic [1:0]  reg_idx;
    logic        wr_en;

    logic        q_push;
    t_job        q_in;
    logic        q_pop;
    t_job        q_head;
    logic        q_empty;
    logic        q_full;

    logic [PAYLOAD_LEN-1:0][7:0] payload;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign payload = {r_payload_high, r_payload_low};

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_low  <= 64'h0706050403020100;
            r_payload_high <= 16'h0908;
            r_ack_value    <= 8'hCC;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PAYLOAD_LOW:  r_payload_low  <= pwdata;
                REG_PAYLOAD_HIGH: r_payload_high <= pwdata[15:0];
                REG_ACK_VALUE:    r_ack_value    <= pwdata[7:0];
                default:          r_ack_value    <= r_ack_value;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_PAYLOAD_LOW:  prdata = r_payload_low;
            REG_PAYLOAD_HIGH: prdata = {48'd0, r_payload_high};
            REG_ACK_VALUE:    prdata = {56'd0, r_ack_value};
            default:          prdata = 64'd0;
        endcase
    end

    assign o_in_stall = q_full;

    rsx_front #(
        .READ_LEN (READ_LEN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_full          (q_full),
        .i_action        (i_action),
        .i_slave_address (i_slave_address),
        .i_command       (i_command),
        .i_rx_byte       (i_rx_byte),
        .i_ack_value     (r_ack_value),
        .o_push          (q_push),
        .o_job           (q_in)
    );

    rsx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rsx_back #(
        .READ_LEN (READ_LEN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .i_payload       (payload),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_byte_value    (o_byte_value),
        .o_ninth_bit     (o_ninth_bit),
        .o_driver_enable (o_driver_enable),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

### verif/rs485_master_exchange_tb.sv
`timescale 1ns / 1ps

module rs485_master_exchange_tb;

    import rsx_pkg::*;

    localparam int READ_N         = 3;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    // action codes of an input item
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_RX    = 1'b1;

    typedef enum logic [2:0] {
        XS_IDLE,
        XS_ADDR_ECHO,
        XS_CMD_ECHO,
        XS_ACK,
        XS_DATA,
        XS_SUM
    } t_xs_phase;

    // ways a generated exchange departs from the well-formed sequence
    typedef enum int {
        FLAW_NONE,
        FLAW_ADDR_ECHO,
        FLAW_CMD_ECHO,
        FLAW_ACK,
        FLAW_SUM,
        FLAW_ABORT
    } t_flaw;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       ninth;
        logic       de;
        logic [2:0] status;
        logic       last;
    } t_exch_result;

    // Line exchange predictor plus queue of results still due
    class exchange_scoreboard;
        t_xs_phase    phase;
        logic [7:0]   cur_addr;
        logic [7:0]   cur_cmd;
        logic [7:0]   read_sum;
        int unsigned  read_cnt;
        logic [7:0]   read_data [READ_N];
        logic [63:0]  pay_lo;
        logic [15:0]  pay_hi;
        logic [7:0]   ack;
        t_exch_result due [$];
        int unsigned  errors;

        function new();
            phase    = XS_IDLE;
            cur_addr = 8'h00;
            cur_cmd  = 8'h00;
            read_sum = 8'h00;
            read_cnt = 0;
            foreach (read_data[i]) read_data[i] = 8'h00;
            pay_lo   = 64'h0706050403020100;
            pay_hi   = 16'h0908;
            ack      = 8'hCC;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_PAYLOAD_LOW:  pay_lo = val;
                REG_PAYLOAD_HIGH: pay_hi = val[15:0];
                REG_ACK_VALUE:    ack    = val[7:0];
                default: ;
            endcase
        endfunction

        function void push(logic [1:0] k, logic [7:0] v, logic n, logic d,
                           logic [2:0] s, logic l);
            due.push_back({k, v, n, d, s, l});
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        // Advance the exchange by one accepted item
        function void note_item(logic act, logic [7:0] addr, logic [7:0] cmd, logic [7:0] rx);
            logic [7:0] wsum;
            logic [7:0] pb;
            if (act == ACT_START) begin
                cur_addr = addr;
                cur_cmd  = cmd;
                read_sum = 8'h00;
                read_cnt = 0;
                phase    = XS_ADDR_ECHO;
                push(KIND_TX, addr, 1'b1, 1'b1, ST_OK, 1'b1);
                return;
            end
            case (phase)
                XS_ADDR_ECHO: begin
                    if (rx != cur_addr) begin
                        phase = XS_IDLE;
                        push(KIND_DONE, 8'h00, 1'b0, 1'b0, ST_ADDR_BAD, 1'b1);
                    end else if (cur_cmd == CMD_WRITE || cur_cmd == CMD_READ) begin
                        phase = XS_CMD_ECHO;
                        push(KIND_TX, cur_cmd, 1'b0, 1'b1, ST_OK, 1'b1);
                    end else begin
                        // unknown command ends cleanly as a no-op
                        phase = XS_IDLE;
                        push(KIND_DONE, 8'h00, 1'b0, 1'b0, ST_OK, 1'b1);
                    end
                end
                XS_CMD_ECHO: begin
                    if (rx != cur_cmd) begin
                        phase = XS_IDLE;
                        push(KIND_DONE, 8'h00, 1'b0, 1'b0, ST_NOT_RDY, 1'b1);
                    end else if (cur_cmd == CMD_WRITE) begin
                        // payload burst then its 8-bit sum
                        wsum = 8'h00;
                        for (int i = 0; i < PAYLOAD_LEN; i++) begin
                            pb   = (i < 8) ? pay_lo[8*i +: 8] : pay_hi[8*(i-8) +: 8];
                            wsum = wsum + pb;
                            push(KIND_TX, pb, 1'b0, 1'b1, ST_OK, 1'b0);
                        end
                        push(KIND_TX, wsum, 1'b0, 1'b1, ST_OK, 1'b1);
                        phase = XS_ACK;
                    end else begin
                        read_sum = 8'h00;
                        read_cnt = 0;
                        phase    = XS_DATA;
                    end
                end
                XS_ACK: begin
                    phase = XS_IDLE;
                    push(KIND_DONE, 8'h00, 1'b0, 1'b0,
                         (rx == ack) ? ST_OK : ST_BAD_ACK, 1'b1);
                end
                XS_DATA: begin
                    read_data[read_cnt] = rx;
                    read_sum = read_sum + rx;
                    read_cnt++;
                    if (read_cnt >= READ_N) phase = XS_SUM;
                end
                XS_SUM: begin
                    phase = XS_IDLE;
                    if (rx != read_sum) begin
                        push(KIND_DONE, 8'h00, 1'b0, 1'b0, ST_SUM_BAD, 1'b1);
                    end else begin
                        for (int i = 0; i < READ_N; i++)
                            push(KIND_DATA, read_data[i], 1'b0, 1'b0, ST_OK, 1'b0);
                        push(KIND_DONE, 8'h00, 1'b0, 1'b0, ST_OK, 1'b1);
                    end
                end
                default: ;  // byte while idle is dropped
            endcase
        endfunction

        task check_result(t_exch_result got);
            t_exch_result want;
            if (due.size() == 0) begin
                report_mismatch($sformatf("result with nothing due: %p", got));
                return;
            end
            want = due.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %h, want %h", got.kind, want.kind));
            if (got.value !== want.value)
                report_mismatch($sformatf("byte_value %h, want %h", got.value, want.value));
            if (got.ninth !== want.ninth)
                report_mismatch($sformatf("ninth_bit %b, want %b", got.ninth, want.ninth));
            if (got.de !== want.de)
                report_mismatch($sformatf("driver_enable %b, want %b", got.de, want.de));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %h, want %h", got.status, want.status));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic        i_action        = 1'b0;
    logic [7:0]  i_slave_address = 8'h00;
    logic [7:0]  i_command       = 8'h00;
    logic [7:0]  i_rx_byte       = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte_value;
    logic        o_ninth_bit;
    logic        o_driver_enable;
    logic [2:0]  o_status;
    logic        o_last;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [4:0]  paddr           = 5'd0;
    logic [63:0] pwdata          = 64'h0;
    logic [63:0] prdata;
    logic        pready;

    exchange_scoreboard sb = new();

    bit in_calm   = 1'b0;
    bit out_calm  = 1'b0;
    bit long_hold = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    rs485_master_exchange #(
        .READ_LEN(READ_N)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_slave_address(i_slave_address),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_byte_value   (o_byte_value),
        .o_ninth_bit    (o_ninth_bit),
        .o_driver_enable(o_driver_enable),
        .o_status       (o_status),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(t_exch_result'({o_kind, o_byte_value, o_ninth_bit,
                                            o_driver_enable, o_status, o_last}));
    end

    // Watchdog: too long without any item moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result sink: random hold before each item, plus one long hold on request
    initial begin : result_sink
        int hold_n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold_n = out_calm ? 0 : $urandom_range(0, 13);
            if (long_hold) begin
                hold_n    = hold_n + LONG_HOLD;
                long_hold = 1'b0;
            end
            i_out_stall <= (hold_n > 0);
            if (hold_n > 0) begin
                repeat (hold_n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] flip_bit(logic [7:0] v);
        return v ^ (8'd1 << $urandom_range(0, 7));
    endfunction

    task automatic send_item(input logic act, input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [7:0] rx, input bit counted);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_slave_address <= addr;
        i_command       <= cmd;
        i_rx_byte       <= rx;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(act, addr, cmd, rx);
        if (counted) items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(ACT_RX, rnd8(), rnd8(), b, 1'b1);
    endtask

    // One exchange as the slave would answer it, optionally broken
    task automatic run_exchange(input logic [7:0] addr, input logic [7:0] cmd,
                                input t_flaw flaw);
        logic [7:0] csum;
        logic [7:0] dbyte;
        int stop_at;
        stop_at = (flaw == FLAW_ABORT) ? $urandom_range(1, 6) : 99;
        send_item(ACT_START, addr, cmd, rnd8(), 1'b1);
        if (stop_at == 1) return;
        send_rx((flaw == FLAW_ADDR_ECHO) ? flip_bit(addr) : addr);
        if (flaw == FLAW_ADDR_ECHO || (cmd != CMD_WRITE && cmd != CMD_READ) || stop_at == 2)
            return;
        send_rx((flaw == FLAW_CMD_ECHO) ? flip_bit(cmd) : cmd);
        if (flaw == FLAW_CMD_ECHO || stop_at == 3) return;
        if (cmd == CMD_WRITE) begin
            send_rx((flaw == FLAW_ACK) ? flip_bit(sb.ack) : sb.ack);
            return;
        end
        csum = 8'h00;
        for (int i = 0; i < READ_N; i++) begin
            if (stop_at == 4 + i) return;
            dbyte = rnd8();
            csum  = csum + dbyte;
            send_rx(dbyte);
        end
        send_rx((flaw == FLAW_SUM) ? flip_bit(csum) : csum);
    endtask

    // Stop offering items and wait for every due result, then the pipeline tail
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Close any open exchange with a no-op so the block is idle
    task automatic settle();
        logic [7:0] addr;
        logic [7:0] cmd;
        if (sb.phase != XS_IDLE) begin
            addr = rnd8();
            cmd  = rnd8();
            if (cmd == CMD_WRITE || cmd == CMD_READ) cmd = 8'h00;
            run_exchange(addr, cmd, FLAW_NONE);
        end
        drain();
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [63:0] lo, input logic [15:0] hi,
                                 input logic [7:0] ackv);
        settle();
        reg_write(REG_PAYLOAD_LOW, lo);
        reg_write(REG_PAYLOAD_HIGH, {48'h0, hi});
        reg_write(REG_ACK_VALUE, {56'h0, ackv});
    endtask

    task automatic random_phase(input int n_items);
        int goal;
        int pick;
        logic [7:0] cmd;
        t_flaw flaw;
        goal     = items_sent + n_items;
        in_calm  = 1'b0;
        out_calm = 1'b0;
        while (items_sent < goal) begin
            if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
            if ($urandom_range(0, 9) == 0) out_calm = !out_calm;
            // stray byte on an idle line
            if (sb.phase == XS_IDLE && $urandom_range(0, 19) == 0)
                send_item(ACT_RX, rnd8(), rnd8(), rnd8(), 1'b0);
            pick = $urandom_range(0, 9);
            cmd  = (pick < 4) ? CMD_WRITE : (pick < 8) ? CMD_READ : rnd8();
            flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : t_flaw'($urandom_range(1, 5));
            run_exchange(rnd8(), cmd, flaw);
        end
        in_calm  = 1'b0;
        out_calm = 1'b0;
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases at reset register values
        run_exchange(8'hFF, CMD_WRITE, FLAW_NONE);
        run_exchange(8'h00, CMD_READ, FLAW_NONE);
        run_exchange(8'hA5, 8'hFF, FLAW_NONE);
        run_exchange(8'h5A, 8'h00, FLAW_ADDR_ECHO);
        run_exchange(8'h3C, CMD_READ, FLAW_CMD_ECHO);
        run_exchange(8'hC3, CMD_WRITE, FLAW_ACK);
        run_exchange(8'h81, CMD_READ, FLAW_SUM);
        send_item(ACT_RX, 8'h00, 8'h00, 8'hFF, 1'b0);
        // restart while waiting for a command echo
        send_item(ACT_START, 8'h12, CMD_WRITE, 8'h00, 1'b1);
        send_rx(8'h12);
        run_exchange(8'h7E, 8'h55, FLAW_NONE);
        drain();

        apply_setting(64'h0, 16'h0000, 8'h00);
        random_phase(90);
        apply_setting({64{1'b1}}, 16'hFFFF, 8'hFF);
        random_phase(90);

        // back-pressure: sink holds off while writes keep coming
        settle();
        long_hold = 1'b1;
        in_calm   = 1'b1;
        repeat (6) run_exchange(rnd8(), CMD_WRITE, FLAW_NONE);
        in_calm   = 1'b0;
        drain();

        repeat (3) begin
            apply_setting({$urandom, $urandom}, 16'($urandom), rnd8());
            random_phase(90);
        end

        drain();
        if (sb.pending() != 0) sb.report_mismatch("expected results left over");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
